### src/tcss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn count speed sequencer package
// Shared widths, codes, types and helpers for the sequencer core.
// ----------------------------------------------------------------------------
package tcss_pkg;

  localparam int unsigned MAX_GROUPS = 4;
  localparam int unsigned GRP_W      = 2;
  localparam int unsigned NGRP_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 39;
  localparam int unsigned TURN_W     = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned PULSE_W    = 8;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned MC_W       = 3;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Commands carried by an input word
  localparam logic [CMD_W-1:0] CMD_PULSE       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESET_GROUP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESET_FIRST = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BRAKE_DONE  = 3'd5;

  // Run phases
  localparam logic [PHASE_W-1:0] PH_STANDBY    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RUN        = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LOW        = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BRAKING    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BRAKE_DONE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PAUSE      = 3'd5;
  localparam logic [PHASE_W-1:0] PH_FINISH     = 3'd6;

  // Motor commands
  localparam logic [MC_W-1:0] MC_NONE    = 3'd0;
  localparam logic [MC_W-1:0] MC_HIGH    = 3'd1;
  localparam logic [MC_W-1:0] MC_LOW     = 3'd2;
  localparam logic [MC_W-1:0] MC_BRAKE   = 3'd3;
  localparam logic [MC_W-1:0] MC_RELEASE = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_TURN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_LEAD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP0      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP1      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP2      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP3      = 3'd7;

  typedef struct packed {
    logic [TURN_W-1:0] goal_low;
    logic [TURN_W-1:0] goal_high;
    logic [PCT_W-1:0]  speed_high;
  } group_load_t;

  typedef struct packed {
    logic [NGRP_W-1:0]  n_groups;
    logic [PULSE_W-1:0] pulses_per_turn;
    logic [PCT_W-1:0]   speed_low;
    logic [TURN_W-1:0]  cur_target;
    group_load_t        load;
  } cfg_view_t;

  typedef struct packed {
    logic [PHASE_W-1:0] run_state;
    logic [GRP_W-1:0]   group_index;
    logic [TURN_W-1:0]  turns_done;
    logic [TURN_W-1:0]  low_turns_done;
    logic [MC_W-1:0]    motor_command;
    logic [PCT_W-1:0]   speed_pct;
    logic [TURN_W-1:0]  product_count;
    logic               count_saved;
  } result_t;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
    sat_pct = (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

### src/tcss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn count speed sequencer channels
// Valid/ready channels for input event words and result words.
// ----------------------------------------------------------------------------
interface tcss_item_if;
  logic                       valid;
  logic                       ready;
  logic [tcss_pkg::CMD_W-1:0] command;
  logic                       working_page;

  modport source (output valid, command, working_page, input ready);
  modport sink   (input valid, command, working_page, output ready);
endinterface

interface tcss_result_if;
  logic                         valid;
  logic                         ready;
  logic [tcss_pkg::PHASE_W-1:0] run_state;
  logic [tcss_pkg::GRP_W-1:0]   group_index;
  logic [tcss_pkg::TURN_W-1:0]  turns_done;
  logic [tcss_pkg::TURN_W-1:0]  low_turns_done;
  logic [tcss_pkg::MC_W-1:0]    motor_command;
  logic [tcss_pkg::PCT_W-1:0]   speed_pct;
  logic [tcss_pkg::TURN_W-1:0]  product_count;
  logic                         count_saved;

  modport source (output valid, run_state, group_index, turns_done, low_turns_done,
                  motor_command, speed_pct, product_count, count_saved, input ready);
  modport sink   (input valid, run_state, group_index, turns_done, low_turns_done,
                  motor_command, speed_pct, product_count, count_saved, output ready);
endinterface

### src/tcss_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn count speed sequencer configuration
// Holds the configuration registers and derives group goals and speeds.
// ----------------------------------------------------------------------------
module tcss_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tcss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [tcss_pkg::GRP_W-1:0]     cur_group_i,
  input  logic [tcss_pkg::GRP_W-1:0]     load_idx_i,
  output tcss_pkg::cfg_view_t            cfg_o
);
  import tcss_pkg::*;

  logic [NGRP_W-1:0]     num_groups_q;
  logic [PULSE_W-1:0]    ppt_q;
  logic [TURN_W-1:0]     sys_lead_q;
  logic [PCT_W-1:0]      sys_speed_q;
  logic [CFG_DATA_W-1:0] group_q [MAX_GROUPS];

  logic [CFG_DATA_W-1:0] load_word;
  logic [TURN_W:0]       tgt_ext;
  logic [TURN_W:0]       lead_sum;
  logic [TURN_W:0]       lead_clip;
  logic [TURN_W:0]       high_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_groups_q <= '0;
      ppt_q        <= 8'd1;
      sys_lead_q   <= '0;
      sys_speed_q  <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        group_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_GROUPS:  num_groups_q <= cfg_data_i[NGRP_W-1:0];
        CFG_PULSES_TURN: ppt_q        <= cfg_data_i[PULSE_W-1:0];
        CFG_SYS_LEAD:    sys_lead_q   <= cfg_data_i[TURN_W-1:0];
        CFG_SYS_SPEED:   sys_speed_q  <= cfg_data_i[PCT_W-1:0];
        CFG_GROUP0:      group_q[0]   <= cfg_data_i;
        CFG_GROUP1:      group_q[1]   <= cfg_data_i;
        CFG_GROUP2:      group_q[2]   <= cfg_data_i;
        CFG_GROUP3:      group_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Lead is system plus group lead, clipped to the target
  always_comb begin
    load_word = group_q[load_idx_i];
    tgt_ext   = {1'b0, load_word[15:0]};
    lead_sum  = {1'b0, sys_lead_q} + {1'b0, load_word[31:16]};
    lead_clip = (lead_sum > tgt_ext) ? tgt_ext : lead_sum;
    high_ext  = tgt_ext - lead_clip;

    cfg_o.n_groups        = (num_groups_q > NGRP_W'(MAX_GROUPS)) ?
                            NGRP_W'(MAX_GROUPS) : num_groups_q;
    cfg_o.pulses_per_turn = ppt_q;
    cfg_o.speed_low       = sat_pct(sys_speed_q);
    cfg_o.cur_target      = group_q[cur_group_i][15:0];
    cfg_o.load.goal_low   = lead_clip[TURN_W-1:0];
    cfg_o.load.goal_high  = high_ext[TURN_W-1:0];
    cfg_o.load.speed_high = sat_pct(load_word[38:32]);
  end

endmodule

### src/turn_count_speed_sequencer_core.sv
`timescale 1ns / 1ps
// Latency: a result word is valid in the cycle after its event word is accepted.
// Throughput: one event word per cycle; the only stall is a full result register
//   whose word the sink has not taken.
// Reset: asynchronous, active low; phase standby, group 0, all counters, goals and
//   speeds zero, configuration back to its defaults, result register empty.
// ----------------------------------------------------------------------------
// Turn count speed sequencer core
// Event-driven winding sequencer: counts encoder pulses into turns, walks a run
// through high speed, low speed and braking, and steps through winding groups.
// ----------------------------------------------------------------------------
module turn_count_speed_sequencer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tcss_item_if.sink                       item_in,
  tcss_result_if.source                   result_out
);
  import tcss_pkg::*;

  // Sequencer state
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [GRP_W-1:0]   group_q, group_d;
  logic [PULSE_W-1:0] pulse_q, pulse_d;
  logic [TURN_W-1:0]  turn_q, turn_d;
  logic [TURN_W-1:0]  low_q, low_d;
  logic [TURN_W-1:0]  fin_q, fin_d;
  logic [TURN_W-1:0]  goal_low_q, goal_low_d;
  logic [TURN_W-1:0]  goal_high_q, goal_high_d;
  logic [PCT_W-1:0]   speed_high_q, speed_high_d;
  logic [PCT_W-1:0]   speed_low_q, speed_low_d;

  // Result register
  logic    out_valid_q;
  result_t res_q, res_d;

  logic       accept;
  logic       in_ready;
  cfg_view_t  cfg;
  logic [CMD_W-1:0]  cmd;
  logic              page;
  logic              enabled;
  logic [NGRP_W-1:0] next_grp;
  logic              wrap;
  logic [GRP_W-1:0]  load_idx;

  // Combinational scratch for one step
  logic [PULSE_W-1:0] pc_inc;
  logic               do_load;
  logic [MC_W-1:0]    mc;
  logic [PCT_W-1:0]   sp;
  logic               saved;
  logic [TURN_W-1:0]  cmp_turns;
  logic [TURN_W-1:0]  cmp_goal;

  // Advance whenever the result register is empty or being drained
  assign in_ready       = !out_valid_q || result_out.ready;
  assign item_in.ready  = in_ready;
  assign accept         = item_in.valid && in_ready;
  assign cmd            = item_in.command;
  assign page           = item_in.working_page;
  assign enabled        = (cfg.n_groups != '0);

  // Group that a load would pick: next group on start from finish, first group on
  // reset to first, else the current one
  assign next_grp = {1'b0, group_q} + NGRP_W'(1);
  assign wrap     = (next_grp >= cfg.n_groups);
  always_comb begin
    if (cmd == CMD_START) begin
      load_idx = wrap ? '0 : next_grp[GRP_W-1:0];
    end else if (cmd == CMD_RESET_FIRST) begin
      load_idx = '0;
    end else begin
      load_idx = group_q;
    end
  end

  tcss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cur_group_i (group_q),
    .load_idx_i  (load_idx),
    .cfg_o       (cfg)
  );

  always_comb begin
    phase_d      = phase_q;
    group_d      = group_q;
    pulse_d      = pulse_q;
    turn_d       = turn_q;
    low_d        = low_q;
    fin_d        = fin_q;
    goal_low_d   = goal_low_q;
    goal_high_d  = goal_high_q;
    speed_high_d = speed_high_q;
    speed_low_d  = speed_low_q;
    pc_inc       = pulse_q + PULSE_W'(1);
    do_load      = 1'b0;
    mc           = MC_NONE;
    sp           = '0;
    saved        = 1'b0;
    cmp_turns    = turn_q;
    cmp_goal     = goal_high_q;

    // Pulse: count turns regardless of page, change phase only on the page
    if (cmd == CMD_PULSE && enabled) begin
      pulse_d = pc_inc;
      if (pc_inc >= cfg.pulses_per_turn) begin
        pulse_d = '0;
        turn_d  = turn_q + TURN_W'(1);
        if (phase_q == PH_LOW) begin
          low_d = low_q + TURN_W'(1);
        end
      end
      if (page) begin
        if (phase_q == PH_RUN) begin
          if (turn_d >= goal_high_q) begin
            phase_d = PH_LOW;
            mc      = MC_LOW;
            sp      = speed_low_q;
          end
        end else if (phase_q == PH_LOW) begin
          if (low_d >= goal_low_q || turn_d >= cfg.cur_target) begin
            phase_d = PH_BRAKING;
            mc      = MC_BRAKE;
          end
        end
      end
    end

    // Brake done acts in braking only, on or off the page
    if (cmd == CMD_BRAKE_DONE && phase_d == PH_BRAKING) begin
      phase_d = PH_BRAKE_DONE;
    end

    // Sequencing pass
    if (page && enabled) begin
      case (phase_d)
        PH_FINISH, PH_STANDBY, PH_PAUSE: begin
          if (cmd == CMD_START) begin
            if (phase_d == PH_FINISH) begin
              do_load = 1'b1;
              if (wrap) begin
                fin_d = fin_q + TURN_W'(1);
                saved = 1'b1;
              end
            end
            // Compare against the freshly loaded group when advancing
            cmp_turns = do_load ? '0 : turn_d;
            cmp_goal  = do_load ? cfg.load.goal_high : goal_high_q;
            if (cmp_turns < cmp_goal) begin
              phase_d = PH_RUN;
              mc      = MC_HIGH;
              sp      = do_load ? cfg.load.speed_high : speed_high_q;
            end else begin
              phase_d = PH_LOW;
              mc      = MC_LOW;
              sp      = do_load ? cfg.speed_low : speed_low_q;
            end
          end else if (cmd == CMD_RESET_GROUP) begin
            // Drop a reset for a group out of use
            if ({1'b0, group_q} < cfg.n_groups) begin
              do_load = 1'b1;
              phase_d = PH_STANDBY;
            end
          end else if (cmd == CMD_RESET_FIRST) begin
            do_load = 1'b1;
            phase_d = PH_STANDBY;
          end
        end
        PH_RUN: begin
          if (cmd == CMD_STOP) begin
            phase_d = PH_LOW;
            mc      = MC_LOW;
            sp      = speed_low_q;
          end
        end
        PH_BRAKE_DONE: begin
          mc      = MC_RELEASE;
          phase_d = (turn_d >= cfg.cur_target) ? PH_FINISH : PH_PAUSE;
        end
        PH_LOW, PH_BRAKING: ;
        default: begin
          phase_d = PH_STANDBY;
        end
      endcase
    end

    // Latch the selected group's goals and speeds, clear the group counters
    if (do_load) begin
      group_d      = load_idx;
      turn_d       = '0;
      low_d        = '0;
      goal_low_d   = cfg.load.goal_low;
      goal_high_d  = cfg.load.goal_high;
      speed_high_d = cfg.load.speed_high;
      speed_low_d  = cfg.speed_low;
    end

    res_d.run_state      = phase_d;
    res_d.group_index    = group_d;
    res_d.turns_done     = turn_d;
    res_d.low_turns_done = low_d;
    res_d.motor_command  = mc;
    res_d.speed_pct      = sp;
    res_d.product_count  = fin_d;
    res_d.count_saved    = saved;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_STANDBY;
      group_q      <= '0;
      pulse_q      <= '0;
      turn_q       <= '0;
      low_q        <= '0;
      fin_q        <= '0;
      goal_low_q   <= '0;
      goal_high_q  <= '0;
      speed_high_q <= '0;
      speed_low_q  <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      group_q      <= group_d;
      pulse_q      <= pulse_d;
      turn_q       <= turn_d;
      low_q        <= low_d;
      fin_q        <= fin_d;
      goal_low_q   <= goal_low_d;
      goal_high_q  <= goal_high_d;
      speed_high_q <= speed_high_d;
      speed_low_q  <= speed_low_d;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_out.valid          = out_valid_q;
  assign result_out.run_state      = res_q.run_state;
  assign result_out.group_index    = res_q.group_index;
  assign result_out.turns_done     = res_q.turns_done;
  assign result_out.low_turns_done = res_q.low_turns_done;
  assign result_out.motor_command  = res_q.motor_command;
  assign result_out.speed_pct      = res_q.speed_pct;
  assign result_out.product_count  = res_q.product_count;
  assign result_out.count_saved    = res_q.count_saved;

  // A saved flag always goes with a product count one higher than before
  a_saved_bumps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_d.count_saved) |=> (fin_q == $past(fin_q) + TURN_W'(1)))
    else $error("count_saved without product count increment");

  // With no groups in use the turn and product counters stay put
  a_disabled_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !enabled) |=> ($stable(turn_q) && $stable(fin_q) && $stable(group_q)))
    else $error("counters moved with no groups in use");

  // Brake release only comes out of the brake-done phase
  a_release_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_d.motor_command == MC_RELEASE) |->
      (phase_q == PH_BRAKE_DONE || (phase_q == PH_BRAKING && cmd == CMD_BRAKE_DONE)))
    else $error("brake release outside brake done");

endmodule

### verif/turn_count_speed_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn count speed sequencer core testbench
// Feeds encoder pulses and operator events through the sequencer under several
// group setups. Each result word is checked field by field against a behavioural
// copy of the winder, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module turn_count_speed_sequencer_core_tb;
  import tcss_pkg::*;

  // Command codes that carry no event; the sequencing pass still runs on them
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // Slowest run: ~900 words, each behind a long source gap and a long sink stall
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PRINT_CAP   = 30;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tcss_item_if   item_ch ();
  tcss_result_if result_ch ();

  turn_count_speed_sequencer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_in    (item_ch),
    .result_out (result_ch)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Winder model: configuration copy and run state
  // --------------------------------------------------------------------------
  logic [NGRP_W-1:0]     m_groups;
  logic [PULSE_W-1:0]    m_ppt;
  logic [TURN_W-1:0]     m_sys_lead;
  logic [PCT_W-1:0]      m_sys_speed;
  logic [CFG_DATA_W-1:0] m_group_word [MAX_GROUPS];

  logic [PHASE_W-1:0] w_phase;
  logic [GRP_W-1:0]   w_group;
  logic [PULSE_W-1:0] w_pulses;
  logic [TURN_W-1:0]  w_turns;
  logic [TURN_W-1:0]  w_low_turns;
  logic [TURN_W-1:0]  w_products;
  logic [TURN_W-1:0]  w_goal_low;
  logic [TURN_W-1:0]  w_goal_high;
  logic [PCT_W-1:0]   w_speed_high;
  logic [PCT_W-1:0]   w_speed_low;

  // Status words still owed by the block, oldest first
  result_t pending_status [$];

  int unsigned fault_count;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned reg_writes;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned stall_left;

  // Values above the parameter limit behave as the limit
  function automatic int unsigned active_groups();
    return (m_groups > MAX_GROUPS) ? MAX_GROUPS : int'(m_groups);
  endfunction

  // Latch target, lead and speeds of a group; a group out of use is left alone
  function automatic void latch_group(input int unsigned g);
    logic [CFG_DATA_W-1:0] word;
    logic [TURN_W:0]       lead;
    logic [TURN_W-1:0]     tgt;
    if (g < active_groups()) begin
      word        = m_group_word[g];
      w_phase     = PH_STANDBY;
      w_group     = g[GRP_W-1:0];
      w_turns     = '0;
      w_low_turns = '0;
      tgt         = word[15:0];
      lead        = {1'b0, m_sys_lead} + {1'b0, word[31:16]};
      // clip the lead so it never exceeds the target
      if (lead > {1'b0, tgt}) lead = {1'b0, tgt};
      w_goal_low   = lead[TURN_W-1:0];
      w_goal_high  = tgt - lead[TURN_W-1:0];
      w_speed_high = (word[38:32] > PCT_MAX) ? PCT_MAX : word[38:32];
      w_speed_low  = (m_sys_speed > PCT_MAX) ? PCT_MAX : m_sys_speed;
    end
  endfunction

  // Advance the winder by one event word and return the status it reports
  function automatic result_t wind_step(input logic [CMD_W-1:0] cmd, input logic page);
    result_t           r;
    int unsigned       n;
    int unsigned       g;
    logic [TURN_W-1:0] target;
    r      = '0;
    n      = active_groups();
    target = m_group_word[w_group][TURN_W-1:0];

    // Pulses count off the working page too; phase moves need the page
    if (cmd == CMD_PULSE && n != 0) begin
      w_pulses = w_pulses + 1'b1;
      if (w_pulses >= m_ppt) begin
        w_pulses = '0;
        w_turns  = w_turns + 1'b1;
        if (w_phase == PH_LOW) w_low_turns = w_low_turns + 1'b1;
      end
      if (page) begin
        if (w_phase == PH_RUN) begin
          if (w_turns >= w_goal_high) begin
            w_phase         = PH_LOW;
            r.motor_command = MC_LOW;
            r.speed_pct     = w_speed_low;
          end
        end else if (w_phase == PH_LOW) begin
          if (w_low_turns >= w_goal_low || w_turns >= target) begin
            w_phase         = PH_BRAKING;
            r.motor_command = MC_BRAKE;
          end
        end
      end
    end

    // Brake done acts in braking only, on or off the page
    if (cmd == CMD_BRAKE_DONE && w_phase == PH_BRAKING) w_phase = PH_BRAKE_DONE;

    if (page && n != 0) begin
      case (w_phase)
        PH_FINISH, PH_STANDBY, PH_PAUSE: begin
          if (cmd == CMD_START) begin
            if (w_phase == PH_FINISH) begin
              g = w_group + 1;
              // wrap past the last group in use: one more product done
              if (g >= n) begin
                g               = 0;
                w_products      = w_products + 1'b1;
                r.count_saved   = 1'b1;
              end
              latch_group(g);
            end
            if (w_turns < w_goal_high) begin
              w_phase         = PH_RUN;
              r.motor_command = MC_HIGH;
              r.speed_pct     = w_speed_high;
            end else begin
              w_phase         = PH_LOW;
              r.motor_command = MC_LOW;
              r.speed_pct     = w_speed_low;
            end
          end else if (cmd == CMD_RESET_GROUP) begin
            latch_group(w_group);
          end else if (cmd == CMD_RESET_FIRST) begin
            w_group = '0;
            latch_group(0);
          end
        end
        PH_RUN: begin
          if (cmd == CMD_STOP) begin
            w_phase         = PH_LOW;
            r.motor_command = MC_LOW;
            r.speed_pct     = w_speed_low;
          end
        end
        PH_BRAKE_DONE: begin
          r.motor_command = MC_RELEASE;
          w_phase         = (w_turns >= target) ? PH_FINISH : PH_PAUSE;
        end
        PH_LOW, PH_BRAKING: ;
        default: w_phase = PH_STANDBY;
      endcase
    end

    r.run_state      = w_phase;
    r.group_index    = w_group;
    r.turns_done     = w_turns;
    r.low_turns_done = w_low_turns;
    r.product_count  = w_products;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared helpers
  // --------------------------------------------------------------------------
  task automatic report_fault(input string what);
    if (fault_count < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
    fault_count++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Half the time, fill the bits above the register width with noise
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                    input int unsigned width);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] mask;
    junk = CFG_DATA_W'({$urandom, $urandom});
    mask = ({{(CFG_DATA_W-1){1'b0}}, 1'b1} << width) - 1'b1;
    if ($urandom_range(0, 1) == 0) return value;
    return (junk & ~mask) | (value & mask);
  endfunction

  // Group word: speed [38:32], lead [31:16], target [15:0]
  function automatic logic [CFG_DATA_W-1:0] make_group_word(input int unsigned tmax);
    logic [PCT_W-1:0]  spd;
    logic [TURN_W-1:0] lead;
    logic [TURN_W-1:0] tgt;
    spd  = PCT_W'($urandom_range(0, 127));
    lead = ($urandom_range(0, 7) == 0) ? TURN_W'($urandom_range(0, 65535)) :
                                         TURN_W'($urandom_range(0, 4));
    tgt  = TURN_W'($urandom_range(0, tmax));
    return {spd, lead, tgt};
  endfunction

  // Send one event word; predict its status once the block takes it
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic page);
    int unsigned gap;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      gap           = pick_gap();
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid        = 1'b1;
    item_ch.command      = cmd;
    item_ch.working_page = page;
    do @(posedge clk_i); while (!item_ch.ready);
    pending_status.push_back(wind_step(cmd, page));
    words_sent++;
  endtask

  // Drop valid and hold until every owed status word has come back
  task automatic wait_idle();
    @(negedge clk_i);
    item_ch.valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      CFG_NUM_GROUPS:  m_groups    = data[NGRP_W-1:0];
      CFG_PULSES_TURN: m_ppt       = data[PULSE_W-1:0];
      CFG_SYS_LEAD:    m_sys_lead  = data[TURN_W-1:0];
      CFG_SYS_SPEED:   m_sys_speed = data[PCT_W-1:0];
      default:         m_group_word[idx[GRP_W-1:0]] = data;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Write every register for a new setup; targets stay at or below tmax
  task automatic program_setup(input int unsigned ng, input int unsigned ppt,
                               input int unsigned lead, input int unsigned spd,
                               input int unsigned tmax);
    wait_idle();
    src_idle_pct  = $urandom_range(0, 2) * 25;
    snk_stall_pct = $urandom_range(0, 2) * 25;
    cfg_write(CFG_NUM_GROUPS,  with_junk(CFG_DATA_W'(ng), NGRP_W));
    cfg_write(CFG_PULSES_TURN, with_junk(CFG_DATA_W'(ppt), PULSE_W));
    cfg_write(CFG_SYS_LEAD,    with_junk(CFG_DATA_W'(lead), TURN_W));
    cfg_write(CFG_SYS_SPEED,   with_junk(CFG_DATA_W'(spd), PCT_W));
    for (int g = 0; g < MAX_GROUPS; g++)
      cfg_write(CFG_IDX_W'(CFG_GROUP0 + g), make_group_word(tmax));
  endtask

  // Mostly well-formed runs steered by the predicted phase, the rest noise
  task automatic run_random_words(input int unsigned count);
    logic [CMD_W-1:0] cmd;
    logic             page;
    repeat (count) begin
      page = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 99) < 15) begin
        cmd  = CMD_W'($urandom_range(0, CMD_SPARE_7));
        page = 1'($urandom_range(0, 1));
      end else begin
        case (w_phase)
          PH_STANDBY, PH_PAUSE, PH_FINISH: begin
            if ($urandom_range(0, 9) < 7)      cmd = CMD_START;
            else if ($urandom_range(0, 1) == 0) cmd = CMD_RESET_GROUP;
            else                               cmd = CMD_RESET_FIRST;
          end
          PH_RUN:     cmd = ($urandom_range(0, 29) == 0) ? CMD_STOP : CMD_PULSE;
          PH_BRAKING: cmd = ($urandom_range(0, 3) == 0) ? CMD_PULSE : CMD_BRAKE_DONE;
          default:    cmd = CMD_PULSE;
        endcase
      end
      send_word(cmd, page);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, with stretches of none
  // --------------------------------------------------------------------------
  initial begin
    result_ch.ready = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < snk_stall_pct) begin
        result_ch.ready = 1'b0;
        stall_left      = pick_gap() - 1;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  // Compare each status word taken with the oldest one owed
  always @(posedge clk_i) begin
    result_t due;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_status.size() == 0) begin
        report_fault("status word arrived with none owed");
      end else begin
        due = pending_status.pop_front();
        words_checked++;
        if (result_ch.run_state !== due.run_state)
          report_fault($sformatf("word %0d run_state got %0d want %0d", words_checked,
                                 result_ch.run_state, due.run_state));
        if (result_ch.group_index !== due.group_index)
          report_fault($sformatf("word %0d group_index got %0d want %0d", words_checked,
                                 result_ch.group_index, due.group_index));
        if (result_ch.turns_done !== due.turns_done)
          report_fault($sformatf("word %0d turns_done got %0d want %0d", words_checked,
                                 result_ch.turns_done, due.turns_done));
        if (result_ch.low_turns_done !== due.low_turns_done)
          report_fault($sformatf("word %0d low_turns_done got %0d want %0d", words_checked,
                                 result_ch.low_turns_done, due.low_turns_done));
        if (result_ch.motor_command !== due.motor_command)
          report_fault($sformatf("word %0d motor_command got %0d want %0d", words_checked,
                                 result_ch.motor_command, due.motor_command));
        if (result_ch.speed_pct !== due.speed_pct)
          report_fault($sformatf("word %0d speed_pct got %0d want %0d", words_checked,
                                 result_ch.speed_pct, due.speed_pct));
        if (result_ch.product_count !== due.product_count)
          report_fault($sformatf("word %0d product_count got %0d want %0d", words_checked,
                                 result_ch.product_count, due.product_count));
        if (result_ch.count_saved !== due.count_saved)
          report_fault($sformatf("word %0d count_saved got %0d want %0d", words_checked,
                                 result_ch.count_saved, due.count_saved));
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status words owed", cycle_count,
               pending_status.size());
      $display("turn_count_speed_sequencer_core_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With no groups in use nothing counts and nothing sequences
  task automatic test_disabled();
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_START, 1'b1);
    send_word(CMD_BRAKE_DONE, 1'b0);
    send_word(CMD_SPARE_6, 1'b1);
  endtask

  // Walk two small groups by hand through every phase and every command
  task automatic test_directed_run();
    wait_idle();
    src_idle_pct  = 30;
    snk_stall_pct = 30;
    cfg_write(CFG_NUM_GROUPS, 39'd2);
    cfg_write(CFG_PULSES_TURN, 39'd1);
    cfg_write(CFG_SYS_LEAD, 39'd2);
    cfg_write(CFG_SYS_SPEED, 39'd30);
    cfg_write(CFG_GROUP0, {7'd80, 16'd1, 16'd6});
    // speed above the top percentage: expect it saturated
    cfg_write(CFG_GROUP1, {7'd127, 16'd0, 16'd4});
    cfg_write(CFG_GROUP2, {CFG_DATA_W{1'b1}});
    cfg_write(CFG_GROUP3, '0);

    send_word(CMD_RESET_FIRST, 1'b1);
    send_word(CMD_START, 1'b1);
    send_word(CMD_BRAKE_DONE, 1'b1);   // not braking: ignored
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_PULSE, 1'b0);        // counts, but off the page no phase move
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_BRAKE_DONE, 1'b0);   // brake done holds until back on the page
    send_word(CMD_SPARE_7, 1'b1);
    send_word(CMD_START, 1'b1);        // advance to the next group
    send_word(CMD_STOP, 1'b1);
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_BRAKE_DONE, 1'b1);   // short of target: pause
    send_word(CMD_START, 1'b1);
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_PULSE, 1'b1);
    send_word(CMD_BRAKE_DONE, 1'b1);

    // shrink the group count under the current group, then wrap
    wait_idle();
    cfg_write(CFG_NUM_GROUPS, 39'd1);
    send_word(CMD_RESET_GROUP, 1'b1);  // group out of use: nothing happens
    send_word(CMD_START, 1'b1);        // wrap: product count steps
  endtask

  // Several setups, extremes among them
  task automatic test_random_windings();
    program_setup(4, 1, 1, 40, 12);
    run_random_words(90);

    program_setup(2, 3, 0, 100, 8);
    run_random_words(90);

    // group count above the limit, pulse divider of zero, largest lead and speed
    program_setup(7, 0, 65535, 127, 20);
    cfg_write(CFG_GROUP3, {7'h7F, 16'hFFFF, 16'd5});
    run_random_words(90);

    program_setup(1, 2, 3, 0, 10);
    run_random_words(90);

    // slowest divider: targets kept at one turn or none
    program_setup(3, 255, 0, 55, 1);
    run_random_words(300);

    program_setup(5, 1, 2, 70, 15);
    cfg_write(CFG_GROUP1, {CFG_DATA_W{1'b1}});
    run_random_words(90);

    // zero targets: start lands straight in low speed
    program_setup(4, 1, 0, 100, 0);
    run_random_words(90);
  endtask

  // Switch sequencing off part way through a run and back on
  task automatic test_disable_mid_run();
    program_setup(4, 1, 1, 60, 6);
    run_random_words(20);
    wait_idle();
    cfg_write(CFG_NUM_GROUPS, '0);
    run_random_words(10);
    wait_idle();
    cfg_write(CFG_NUM_GROUPS, 39'd4);
    run_random_words(10);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_NUM_GROUPS;
    cfg_data_i           = '0;
    item_ch.valid        = 1'b0;
    item_ch.command      = CMD_PULSE;
    item_ch.working_page = 1'b0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    fault_count          = 0;
    words_sent           = 0;
    words_checked        = 0;
    reg_writes           = 0;
    cycle_count          = 0;

    // model state after reset
    m_groups     = '0;
    m_ppt        = 8'd1;
    m_sys_lead   = '0;
    m_sys_speed  = '0;
    for (int g = 0; g < MAX_GROUPS; g++) m_group_word[g] = '0;
    w_phase      = PH_STANDBY;
    w_group      = '0;
    w_pulses     = '0;
    w_turns      = '0;
    w_low_turns  = '0;
    w_products   = '0;
    w_goal_low   = '0;
    w_goal_high  = '0;
    w_speed_high = '0;
    w_speed_low  = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_disabled();
    test_directed_run();
    test_random_windings();
    test_disable_mid_run();

    wait_idle();
    repeat (4) @(posedge clk_i);

    $display("checked %0d of %0d event words across %0d register writes", words_checked,
             words_sent, reg_writes);
    $display("setups: no groups, one to over-limit groups, dividers 0/1/2/3/255, %s",
             "zero and largest leads");
    if (fault_count == 0) begin
      $display("turn_count_speed_sequencer_core_tb: done, clean");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("turn_count_speed_sequencer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
